>>> hdl/ufef_pkg.sv
package ufef_pkg;

  localparam int NODE_W    = 12;
  localparam int RAND_W    = 16;
  localparam int INDEX_W   = 14;
  localparam int NCOUNT_W  = 13;
  localparam int THR_W     = 17;
  localparam int CFG_IDX_W = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT           = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRA_EDGE_THRESHOLD = 8'd1;

  localparam logic KIND_BEGIN = 1'b0;

  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RESET = 13'd4096;
  localparam logic [THR_W-1:0]    THRESHOLD_RESET  = 17'd0;

endpackage

>>> hdl/ufef_parent_ram.sv
module ufef_parent_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/union_find_edge_filter_unit.sv
// edge item: accepted in ST_IDLE, then find walks from node_a and node_b over the
// parent memory read port, then ST_DONE presents the result; no new item is taken before that
// begin item: a write pass over all min(MAX_NODES, 4096) parent entries, one per cycle
// reset: synchronous; the same write pass over every parent entry runs after reset
// and no item is taken until it ends; configuration writes are taken at any time
module union_find_edge_filter_unit #(
  parameter int MAX_NODES = 4096,
  parameter int MAX_EDGES = 8192
) (
  input  logic                              clk,
  input  logic                              rst,
  // node_a [11:0], node_b [23:12], random_value [39:24]
  input  logic [ufef_pkg::IN_DATA_W-1:0]    s_tdata,
  // kind [0]
  input  logic                              s_tuser,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // accepted [0], sets_joined [1], edge_a [13:2], edge_b [25:14], accepted_index [39:26]
  output logic [ufef_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ufef_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ufef_pkg::THR_W-1:0]        cfg_data
);

  localparam int DEPTH = (MAX_NODES < 4096) ? MAX_NODES : 4096;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_EDGES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FIND_A,
    ST_FIND_B,
    ST_DONE
  } state_t;

  state_t state;

  logic [ufef_pkg::NCOUNT_W-1:0] node_count;
  logic [ufef_pkg::THR_W-1:0]    threshold;
  logic [CW-1:0]                 count;

  logic [AW-1:0]                 clr_idx;
  logic                          clr_emit;
  logic [AW-1:0]                 cur;
  logic [AW-1:0]                 root_a;
  logic [ufef_pkg::NODE_W-1:0]   edge_a;
  logic [ufef_pkg::NODE_W-1:0]   edge_b;
  logic [ufef_pkg::RAND_W-1:0]   rnd;
  logic                          res_acc;
  logic                          res_joined;

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [AW-1:0]                 mem_wdata;
  logic [AW-1:0]                 mem_raddr;
  logic [AW-1:0]                 mem_rdata;

  logic [ufef_pkg::NODE_W-1:0]   in_a;
  logic [ufef_pkg::NODE_W-1:0]   in_b;
  logic                          in_range;
  logic                          at_root;
  logic                          do_accept;
  logic [CW-1:0]                 count_inc;

  assign in_a = s_tdata[11:0];
  assign in_b = s_tdata[23:12];

  assign in_range = ({1'b0, in_a} < node_count) && ({1'b0, in_b} < node_count) &&
                    ({1'b0, in_a} < 13'(DEPTH)) && ({1'b0, in_b} < 13'(DEPTH));

  assign at_root   = (mem_rdata == cur);
  assign do_accept = (root_a != cur) || ({1'b0, rnd} < threshold);
  assign count_inc = (count < CW'(MAX_EDGES)) ? count + CW'(1) : count;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx;
    mem_wdata = clr_idx;
    mem_raddr = AW'(in_a);
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_FIND_A: begin
        mem_raddr = at_root ? AW'(edge_b) : mem_rdata;
      end
      ST_FIND_B: begin
        mem_raddr = mem_rdata;
        if (at_root && (root_a != cur)) begin
          mem_we    = 1'b1;
          mem_waddr = root_a;
          mem_wdata = cur;
        end
      end
      default: begin
        mem_raddr = AW'(in_a);
      end
    endcase
  end

  ufef_parent_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_parent_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      clr_emit   <= 1'b0;
      count      <= '0;
      m_tvalid   <= 1'b0;
      node_count <= ufef_pkg::NODE_COUNT_RESET;
      threshold  <= ufef_pkg::THRESHOLD_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ufef_pkg::REG_NODE_COUNT:           node_count <= cfg_data[12:0];
          ufef_pkg::REG_EXTRA_EDGE_THRESHOLD: threshold  <= cfg_data;
          default: begin
          end
        endcase
      end

      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            edge_a <= in_a;
            edge_b <= in_b;
            rnd    <= s_tdata[39:24];
            cur    <= AW'(in_a);
            if (s_tuser == ufef_pkg::KIND_BEGIN) begin
              clr_idx  <= '0;
              clr_emit <= 1'b1;
              state    <= ST_CLEAR;
            end else if (in_range) begin
              state <= ST_FIND_A;
            end else begin
              res_acc    <= 1'b0;
              res_joined <= 1'b0;
              state      <= ST_DONE;
            end
          end
        end
        ST_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == AW'(DEPTH - 1)) begin
            count <= '0;
            if (clr_emit) begin
              res_acc    <= 1'b0;
              res_joined <= 1'b0;
              edge_a     <= '0;
              edge_b     <= '0;
              state      <= ST_DONE;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_FIND_A: begin
          if (at_root) begin
            root_a <= cur;
            cur    <= AW'(edge_b);
            state  <= ST_FIND_B;
          end else begin
            cur <= mem_rdata;
          end
        end
        ST_FIND_B: begin
          if (at_root) begin
            res_acc    <= do_accept;
            res_joined <= (root_a != cur);
            if (do_accept) begin
              count <= count_inc;
            end
            state <= ST_DONE;
          end else begin
            cur <= mem_rdata;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {(clr_emit ? {ufef_pkg::INDEX_W{1'b0}} : ufef_pkg::INDEX_W'(count)),
                         edge_b, edge_a, res_joined, res_acc};
            clr_emit <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/testbench.sv
module testbench;

  localparam int NODES_MAX = 4096;
  localparam int EDGES_MAX = 8192;
  localparam int HOLD_CYCLES = 6000;
  localparam int STALL_LIMIT = 100000;
  localparam logic [ufef_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd255;
  localparam logic KIND_EDGE = 1'b1;

  typedef struct packed {
    logic [ufef_pkg::RAND_W-1:0] random_value;
    logic [ufef_pkg::NODE_W-1:0] node_b;
    logic [ufef_pkg::NODE_W-1:0] node_a;
  } edge_word_t;

  typedef struct packed {
    logic       kind;
    edge_word_t word;
  } offer_t;

  typedef struct packed {
    logic [ufef_pkg::INDEX_W-1:0] accepted_index;
    logic [ufef_pkg::NODE_W-1:0]  edge_b;
    logic [ufef_pkg::NODE_W-1:0]  edge_a;
    logic                         sets_joined;
    logic                         accepted;
  } verdict_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic [ufef_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                            s_tuser = 1'b0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [ufef_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [ufef_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ufef_pkg::THR_W-1:0]      cfg_data = '0;

  // predictor state
  logic [ufef_pkg::NODE_W-1:0]   parent_of_node [NODES_MAX];
  logic [ufef_pkg::INDEX_W-1:0]  accepted_total;
  logic [ufef_pkg::NCOUNT_W-1:0] node_limit;
  logic [ufef_pkg::THR_W-1:0]    keep_threshold;

  offer_t   offers_waiting[$];
  verdict_t verdicts_due[$];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  logic     hold_req = 1'b0;
  int       hold_left = 0;
  int       mismatches = 0;
  int       quiet_cycles = 0;

  union_find_edge_filter_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic void clear_partition();
    for (int i = 0; i < NODES_MAX; i++) parent_of_node[i] = ufef_pkg::NODE_W'(i);
    accepted_total = '0;
  endfunction

  function automatic logic [ufef_pkg::NODE_W-1:0] root_of(
      input logic [ufef_pkg::NODE_W-1:0] n);
    logic [ufef_pkg::NODE_W-1:0] cur;
    int step;
    cur = n;
    for (step = 0; step < NODES_MAX; step++) begin
      if (parent_of_node[cur] == cur) break;
      cur = parent_of_node[cur];
    end
    return cur;
  endfunction

  function automatic verdict_t decide_offer(input offer_t it);
    verdict_t v;
    logic [ufef_pkg::NODE_W-1:0] ra;
    logic [ufef_pkg::NODE_W-1:0] rb;
    int lim;
    v = '0;
    if (it.kind == ufef_pkg::KIND_BEGIN) begin
      clear_partition();
      return v;
    end
    lim = (node_limit > NODES_MAX) ? NODES_MAX : int'(node_limit);
    v.edge_a = it.word.node_a;
    v.edge_b = it.word.node_b;
    if (int'(it.word.node_a) < lim && int'(it.word.node_b) < lim) begin
      ra = root_of(it.word.node_a);
      rb = root_of(it.word.node_b);
      if (ra != rb) begin
        v.sets_joined = 1'b1;
        v.accepted = 1'b1;
        parent_of_node[ra] = rb;
      end else if ({1'b0, it.word.random_value} < keep_threshold) begin
        v.accepted = 1'b1;
      end
      if (v.accepted && accepted_total < EDGES_MAX) accepted_total = accepted_total + 1'b1;
    end
    v.accepted_index = accepted_total;
    return v;
  endfunction

  function automatic void push_begin();
    offer_t it;
    it.kind = ufef_pkg::KIND_BEGIN;
    it.word = edge_word_t'(ufef_pkg::IN_DATA_W'({$urandom, $urandom}));
    offers_waiting.push_back(it);
  endfunction

  function automatic void push_edge(input int a, input int b, input int r);
    offer_t it;
    it.kind = KIND_EDGE;
    it.word.node_a = ufef_pkg::NODE_W'(a);
    it.word.node_b = ufef_pkg::NODE_W'(b);
    it.word.random_value = ufef_pkg::RAND_W'(r);
    offers_waiting.push_back(it);
  endfunction

  task automatic write_reg(input logic [ufef_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ufef_pkg::THR_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ufef_pkg::REG_NODE_COUNT) node_limit = val[ufef_pkg::NCOUNT_W-1:0];
    else if (idx == ufef_pkg::REG_EXTRA_EDGE_THRESHOLD) keep_threshold = val;
    @(negedge clk);
  endtask

  task automatic drain();
    while (offers_waiting.size() != 0 || s_tvalid || verdicts_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int nodes_cfg, input int thr_cfg, input int send_pct,
                           input int recv_pct, input int item_goal, input bit squeeze);
    int usable;
    int queued;
    int a;
    int b;
    int r;
    write_reg(ufef_pkg::REG_NODE_COUNT, ufef_pkg::THR_W'(nodes_cfg));
    write_reg(ufef_pkg::REG_EXTRA_EDGE_THRESHOLD, ufef_pkg::THR_W'(thr_cfg));
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    usable = (nodes_cfg > NODES_MAX) ? NODES_MAX : nodes_cfg;
    queued = 0;
    while (queued < item_goal) begin
      // now and then keep growing the old partition
      if ($urandom_range(4) != 0) begin
        push_begin();
        queued++;
      end
      repeat ($urandom_range(60, 10)) begin
        a = $urandom_range(usable - 1);
        b = $urandom_range(usable - 1);
        r = $urandom_range(65535);
        case ($urandom_range(9))
          0: a = $urandom_range(4095);
          1: b = $urandom_range(4095);
          2: a = b;
          3: if (thr_cfg > 0 && thr_cfg <= 65536) r = thr_cfg - 1;
          4: if (thr_cfg <= 65535) r = thr_cfg;
          default: ;
        endcase
        push_edge(a, b, r);
        queued++;
      end
    end
    if (squeeze) begin
      hold_req = 1'b1;
      @(negedge clk);
      hold_req = 1'b0;
    end
    drain();
  endtask

  // driver
  always @(posedge clk) begin
    offer_t next_offer;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) verdicts_due.push_back(decide_offer(offer_t'({s_tuser, s_tdata})));
      if (!s_tvalid || s_tready) begin
        if (offers_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_offer = offers_waiting.pop_front();
          s_tdata <= next_offer.word;
          s_tuser <= next_offer.kind;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // monitor
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = verdict_t'(m_tdata);
        if (verdicts_due.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transfer: %h", m_tdata);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (got.accepted !== want.accepted || got.sets_joined !== want.sets_joined ||
              got.edge_a !== want.edge_a || got.edge_b !== want.edge_b ||
              got.accepted_index !== want.accepted_index) begin
            if (mismatches < 10)
              $display("result mismatch: expected acc=%0d join=%0d a=%0d b=%0d idx=%0d",
                       want.accepted, want.sets_joined, want.edge_a, want.edge_b,
                       want.accepted_index,
                       " got acc=%0d join=%0d a=%0d b=%0d idx=%0d",
                       got.accepted, got.sets_joined, got.edge_a, got.edge_b,
                       got.accepted_index);
            mismatches++;
          end
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    clear_partition();
    node_limit = ufef_pkg::NODE_COUNT_RESET;
    keep_threshold = ufef_pkg::THRESHOLD_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extreme ends, self loops, cycles, out of range ends
    push_begin();
    push_edge(0, 4095, 0);
    push_edge(4095, 0, 0);
    push_edge(5, 5, 65535);
    push_edge(4095, 4095, 0);
    drain();
    write_reg(ufef_pkg::REG_EXTRA_EDGE_THRESHOLD, 17'd65536);
    push_edge(0, 4095, 65535);
    push_edge(7, 7, 65535);
    push_edge(1, 2, 'h5555);
    push_edge(2, 3, 'hAAAA);
    push_edge(3, 1, 'hFFFF);
    drain();
    write_reg(ufef_pkg::REG_NODE_COUNT, 17'd2);
    write_reg(ufef_pkg::REG_EXTRA_EDGE_THRESHOLD, 17'd1);
    push_begin();
    push_edge(0, 1, 1);
    push_edge(1, 0, 0);
    push_edge(1, 0, 1);
    push_edge(2, 0, 0);
    push_edge(0, 4095, 0);
    push_edge(4095, 4095, 0);
    drain();
    write_reg(ufef_pkg::REG_NODE_COUNT, 17'd0);
    write_reg(REG_SPARE, 17'h1FFFF);
    push_edge(0, 0, 0);
    push_edge(1, 0, 0);
    drain();
    write_reg(ufef_pkg::REG_NODE_COUNT, 17'd8191);
    write_reg(ufef_pkg::REG_EXTRA_EDGE_THRESHOLD, 17'h1FFFF);
    push_edge(4095, 0, 65535);
    push_edge(0, 4095, 65535);
    push_edge(4094, 4095, 0);
    drain();

    run_phase(16, 0, 0, 0, 180, 1'b1);
    run_phase(64, 32768, 84, 0, 180, 1'b0);
    run_phase(2, 65535, 0, 84, 180, 1'b0);
    run_phase(4096, 20000, 13, 13, 180, 1'b0);
    run_phase(37, 131071, 0, 0, 180, 1'b0);
    run_phase(200, 6000, 84, 0, 180, 1'b0);
    run_phase(8, 50000, 0, 84, 180, 1'b0);
    run_phase(4096, 0, 13, 13, 180, 1'b0);

    // dense cycles over two nodes, every edge kept
    write_reg(ufef_pkg::REG_NODE_COUNT, 17'd2);
    write_reg(ufef_pkg::REG_EXTRA_EDGE_THRESHOLD, 17'd65536);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_begin();
    repeat (40) push_edge($urandom_range(1), $urandom_range(1), $urandom_range(65535));
    drain();

    repeat (20) @(negedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
